[hw/rtl/cfc_pkg.sv]
package cfc_pkg;

    localparam int HEADER_BYTES_DEF = 24;

    localparam logic [31:0] CRC_POLY     = 32'hEDB88320;
    localparam logic [31:0] ALL_ONES     = 32'hFFFFFFFF;
    localparam logic [7:0]  FRAME_FLAGS  = 8'h03;
    localparam logic [7:0]  FRAME_VER    = 8'h01;

    localparam logic [7:0]  LEVEL_RESET  = 8'd9;
    localparam logic [31:0] LIMIT_RESET  = 32'h7E000000;

    // register index taken from paddr[2]
    localparam logic REG_LEVEL = 1'b0;
    localparam logic REG_LIMIT = 1'b1;

    localparam int BOUND_W = 34;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_TRUNC    = 3'd1,
        ST_MAGIC    = 3'd2,
        ST_FORMAT   = 3'd3,
        ST_MISMATCH = 3'd4,
        ST_LARGE    = 3'd5,
        ST_LENGTH   = 3'd6,
        ST_CRC      = 3'd7
    } t_status;

    typedef struct packed {
        logic [7:0]  level;
        logic [31:0] limit;
    } t_cfg;

    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        logic [7:0] m;
        case (idx)
            2'd0:    m = 8'h48;
            2'd1:    m = 8'h5A;
            2'd2:    m = 8'h34;
            default: m = 8'h31;
        endcase
        return m;
    endfunction

    // reflected CRC-32, one byte
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc_in,
                                               input logic [7:0]  b);
        logic [31:0] c;
        c = crc_in ^ {24'b0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

[hw/rtl/cfc_regs.sv]
module cfc_regs (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic [2:0]        i_paddr,
    input  logic [31:0]       i_pwdata,
    output logic [31:0]       o_prdata,
    output logic              o_pready,
    output cfc_pkg::t_cfg     o_cfg
);
    import cfc_pkg::*;

    logic [7:0]  r_level;
    logic [31:0] r_limit;
    logic        wr_en;

    assign wr_en    = i_psel & i_penable & i_pwrite;
    assign o_pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= LEVEL_RESET;
            r_limit <= LIMIT_RESET;
        end else if (wr_en) begin
            if (i_paddr[2] == REG_LEVEL) begin
                r_level <= i_pwdata[7:0];
            end else begin
                r_limit <= i_pwdata;
            end
        end
    end

    assign o_prdata = (i_paddr[2] == REG_LIMIT) ? r_limit : {24'b0, r_level};

    assign o_cfg.level = r_level;
    assign o_cfg.limit = r_limit;

endmodule

[hw/rtl/cfc_bound.sv]
// Length bound decl + decl/255 + 16, two register stages behind the declared
// size. The size word is complete long before the header ends.
module cfc_bound (
    input  logic                         i_clk,
    input  logic [31:0]                  i_decl,
    output logic [cfc_pkg::BOUND_W-1:0]  o_bound
);
    import cfc_pkg::*;

    localparam logic [31:0] RECIP_255 = 32'h80808081;

    logic [63:0]        r_prod;
    logic [31:0]        r_decl_d;
    logic [BOUND_W-1:0] r_bound;

    always_ff @(posedge i_clk) begin
        r_prod   <= {32'b0, i_decl} * {32'b0, RECIP_255};
        r_decl_d <= i_decl;
        // floor(x/255) == (x * 0x80808081) >> 39 for every 32-bit x
        r_bound  <= BOUND_W'(r_decl_d) + BOUND_W'(r_prod[63:39]) + BOUND_W'(16);
    end

    assign o_bound = r_bound;

endmodule

[hw/rtl/cfc_core.sv]
module cfc_core #(
    parameter int HEADER_BYTES = cfc_pkg::HEADER_BYTES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  cfc_pkg::t_cfg                i_cfg,
    input  logic [cfc_pkg::BOUND_W-1:0]  i_bound,
    output logic [31:0]                  o_decl,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [7:0]                   i_in_byte,
    input  logic                         i_in_last,
    input  logic [31:0]                  i_in_expect,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [7:0]                   o_out_byte,
    output logic                         o_out_bvalid,
    output logic                         o_out_end,
    output logic [2:0]                   o_out_status,
    output logic [31:0]                  o_out_decl,
    output logic [31:0]                  o_out_ocrc
);
    import cfc_pkg::*;

    localparam int          CW        = $clog2(HEADER_BYTES + 1);
    localparam logic [CW-1:0] CNT_END = CW'(HEADER_BYTES);
    localparam logic [7:0]  HDR_SIZE_BYTE = 8'(HEADER_BYTES);

    function automatic t_status latch_err(input t_status cur, input t_status code);
        return (cur == ST_OK) ? code : cur;
    endfunction

    // input stage
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_last;
    logic [31:0] r_in_expect;

    // frame state
    logic [CW-1:0] r_hdr_cnt;
    t_status       r_err;
    logic [31:0]   r_want;
    logic [31:0]   r_decl;
    logic [31:0]   r_comp;
    logic [31:0]   r_body_cnt;
    logic [31:0]   r_crc;
    logic [31:0]   r_body_crc;
    logic [31:0]   r_out_crc;

    // result stage
    logic        r_out_valid;
    logic [7:0]  r_out_byte;
    logic        r_out_bvalid;
    logic        r_out_end;
    logic [2:0]  r_out_status;
    logic [31:0] r_out_decl;
    logic [31:0] r_out_ocrc;

    logic out_free;
    logic adv;

    logic [CW-1:0] n_hdr_cnt;
    t_status       n_err;
    logic [31:0]   n_want;
    logic [31:0]   n_decl;
    logic [31:0]   n_comp;
    logic [31:0]   n_body_cnt;
    logic [31:0]   n_crc;
    logic [31:0]   n_body_crc;
    logic [31:0]   n_out_crc;
    t_status       c_status;
    logic          c_bvalid;
    logic          c_produce;
    logic [CW-1:0] pos;
    logic [7:0]    lane_val;

    assign out_free   = !r_out_valid || i_out_ready;
    assign adv        = r_in_valid && out_free;
    assign o_in_ready = !r_in_valid || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte   <= i_in_byte;
            r_in_last   <= i_in_last;
            r_in_expect <= i_in_expect;
        end
    end

    always_comb begin
        // frame start clears everything and samples the expected size
        if (r_hdr_cnt == '0) begin
            n_err      = ST_OK;
            n_want     = r_in_expect;
            n_decl     = '0;
            n_comp     = '0;
            n_body_cnt = '0;
            n_crc      = ALL_ONES;
            n_body_crc = '0;
            n_out_crc  = '0;
        end else begin
            n_err      = r_err;
            n_want     = r_want;
            n_decl     = r_decl;
            n_comp     = r_comp;
            n_body_cnt = r_body_cnt;
            n_crc      = r_crc;
            n_body_crc = r_body_crc;
            n_out_crc  = r_out_crc;
        end
        pos       = r_hdr_cnt;
        n_hdr_cnt = r_hdr_cnt;
        c_bvalid  = 1'b0;
        lane_val  = r_in_byte;

        if (r_hdr_cnt < CNT_END) begin
            if (pos < CW'(4)) begin
                if (r_in_byte != magic_byte(pos[1:0])) n_err = latch_err(n_err, ST_MAGIC);
            end else if (pos == CW'(4)) begin
                if (r_in_byte != FRAME_VER) n_err = latch_err(n_err, ST_FORMAT);
            end else if (pos == CW'(5)) begin
                if (r_in_byte != i_cfg.level) n_err = latch_err(n_err, ST_FORMAT);
            end else if (pos == CW'(6)) begin
                if (r_in_byte != FRAME_FLAGS) n_err = latch_err(n_err, ST_FORMAT);
            end else if (pos == CW'(7)) begin
                if (r_in_byte != HDR_SIZE_BYTE) n_err = latch_err(n_err, ST_FORMAT);
            end else if (pos < CW'(24)) begin
                // little-endian words: declared, compressed, output crc, body crc
                case (pos[4:2])
                    3'd2:    n_decl[pos[1:0]*8 +: 8]     = lane_val;
                    3'd3:    n_comp[pos[1:0]*8 +: 8]     = lane_val;
                    3'd4:    n_out_crc[pos[1:0]*8 +: 8]  = lane_val;
                    default: n_body_crc[pos[1:0]*8 +: 8] = lane_val;
                endcase
            end
            n_hdr_cnt = r_hdr_cnt + CW'(1);
            if (n_hdr_cnt == CNT_END) begin
                if (n_decl != n_want)      n_err = latch_err(n_err, ST_MISMATCH);
                if (n_decl > i_cfg.limit)  n_err = latch_err(n_err, ST_LARGE);
                if (n_comp == '0 || BOUND_W'(n_comp) > i_bound) begin
                    n_err = latch_err(n_err, ST_LENGTH);
                end
            end
        end else begin
            if (n_body_cnt >= n_comp) n_err = latch_err(n_err, ST_LENGTH);
            if (n_body_cnt != ALL_ONES) n_body_cnt = n_body_cnt + 32'd1;
            n_crc    = crc32_byte(n_crc, r_in_byte);
            c_bvalid = (n_err == ST_OK);
        end

        c_status = n_err;
        if (r_in_last) begin
            if (n_hdr_cnt < CNT_END) begin
                c_status = ST_TRUNC;
            end else begin
                if (n_body_cnt != n_comp) n_err = latch_err(n_err, ST_LENGTH);
                if ((n_crc ^ ALL_ONES) != n_body_crc) n_err = latch_err(n_err, ST_CRC);
                c_status = n_err;
            end
            n_hdr_cnt = '0;
        end
        c_produce = c_bvalid || r_in_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_cnt <= '0;
            r_err     <= ST_OK;
        end else if (adv) begin
            r_hdr_cnt <= n_hdr_cnt;
            r_err     <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_want     <= n_want;
            r_decl     <= n_decl;
            r_comp     <= n_comp;
            r_body_cnt <= n_body_cnt;
            r_crc      <= n_crc;
            r_body_crc <= n_body_crc;
            r_out_crc  <= n_out_crc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= c_produce;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && c_produce) begin
            r_out_byte   <= c_bvalid ? r_in_byte : 8'd0;
            r_out_bvalid <= c_bvalid;
            r_out_end    <= r_in_last;
            r_out_status <= c_status;
            r_out_decl   <= r_in_last ? n_decl : 32'd0;
            r_out_ocrc   <= r_in_last ? n_out_crc : 32'd0;
        end
    end

    assign o_decl       = r_decl;
    assign o_out_valid  = r_out_valid;
    assign o_out_byte   = r_out_byte;
    assign o_out_bvalid = r_out_bvalid;
    assign o_out_end    = r_out_end;
    assign o_out_status = r_out_status;
    assign o_out_decl   = r_out_decl;
    assign o_out_ocrc   = r_out_ocrc;

endmodule

[hw/rtl/compressed_frame_checker_top.sv]
// A result passes the input register, then the result register, to the master side.
// Throughput: one byte per cycle unless the master side stalls, also for bytes that
// produce no result (header bytes, dropped body bytes); the CRC and header checks of
// a byte finish in the single stage between the two registers.
// Reset (synchronous, active low) empties both stages, restarts frame parsing and
// returns compression_level to 9 and size_limit to 0x7E000000.
module compressed_frame_checker_top #(
    parameter int HEADER_BYTES = cfc_pkg::HEADER_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] data_byte, [39:8] target_size
    input  logic [39:0] s_axis_tdata,
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] body_byte, [10:8] status, [42:11] stated_size, [74:43] output_crc,
    // [79:75] zero
    output logic [79:0] m_axis_tdata,
    output logic        m_axis_tlast,
    // [0] byte_valid
    output logic        m_axis_tuser,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import cfc_pkg::*;

    t_cfg               cfg;
    logic [BOUND_W-1:0] bound;
    logic [31:0]        decl;
    logic [7:0]         out_byte;
    logic [2:0]         out_status;
    logic [31:0]        out_decl;
    logic [31:0]        out_ocrc;

    cfc_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_pready  (pready),
        .o_cfg     (cfg)
    );

    cfc_bound u_bound (
        .i_clk   (i_clk),
        .i_decl  (decl),
        .o_bound (bound)
    );

    cfc_core #(
        .HEADER_BYTES (HEADER_BYTES)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_bound      (bound),
        .o_decl       (decl),
        .i_in_valid   (s_axis_tvalid),
        .o_in_ready   (s_axis_tready),
        .i_in_byte    (s_axis_tdata[7:0]),
        .i_in_last    (s_axis_tlast),
        .i_in_expect  (s_axis_tdata[39:8]),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_out_byte   (out_byte),
        .o_out_bvalid (m_axis_tuser),
        .o_out_end    (m_axis_tlast),
        .o_out_status (out_status),
        .o_out_decl   (out_decl),
        .o_out_ocrc   (out_ocrc)
    );

    assign m_axis_tdata = {5'b0, out_ocrc, out_decl, out_status, out_byte};

endmodule

[bench/compressed_frame_checker_top_tb.sv]
module compressed_frame_checker_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cfc_pkg::*;

    localparam int HDR_LEN        = HEADER_BYTES_DEF;
    localparam int RESET_CYCLES   = 10;
    localparam int QUIET_CYCLES   = 8;
    localparam int TAIL_CYCLES    = 20;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASE_BYTES    = 150;
    localparam int MAX_BODY       = 40;

    localparam int NO_FLAW    = -1;
    localparam int FULL_FRAME = 0;

    localparam int OFS_VERSION = 4;
    localparam int OFS_LEVEL   = 5;
    localparam int OFS_FLAGS   = 6;
    localparam int OFS_HSIZE   = 7;
    localparam int OFS_WORDS   = 8;

    localparam logic [2:0] ADDR_LEVEL = {REG_LEVEL, 2'b00};
    localparam logic [2:0] ADDR_LIMIT = {REG_LIMIT, 2'b00};

    localparam logic [7:0] MAGIC [4] = '{8'h48, 8'h5A, 8'h34, 8'h31};

    typedef struct {
        logic [7:0]  data;
        logic        last;
        logic [31:0] want;
    } t_payload_byte;

    typedef struct {
        logic [7:0]  body;
        logic        valid;
        logic        last;
        t_status     status;
        logic [31:0] decl;
        logic [31:0] ocrc;
    } t_frame_out;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [79:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        m_axis_tuser;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    compressed_frame_checker_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_payload_byte payload_q[$];
    t_frame_out    frame_out_q[$];
    t_payload_byte cur_byte;
    t_frame_out    exp_out;

    // configuration as the block should hold it
    logic [7:0]  lvl_cfg = LEVEL_RESET;
    logic [31:0] lim_cfg = LIMIT_RESET;

    // frame parsing state of the predictor
    int          fr_hdr = 0;
    t_status     fr_err = ST_OK;
    logic [31:0] fr_want = '0;
    logic [31:0] fr_decl = '0;
    logic [31:0] fr_comp = '0;
    logic [31:0] fr_body_cnt = '0;
    logic [31:0] fr_crc = ALL_ONES;
    logic [31:0] fr_body_crc = '0;
    logic [31:0] fr_out_crc = '0;

    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    bit hold_arm = 1'b0;
    bit hold_done = 1'b0;
    int hold_left = 0;
    int stall_cycles = 0;

    int n_fail = 0;
    int n_in = 0;
    int n_results = 0;
    int n_frames = 0;
    int bytes_queued = 0;
    int ends_by_status[8] = '{default: 0};

    function automatic logic [31:0] crc_step(input logic [31:0] c, input logic [7:0] d);
        logic [31:0] r;
        r = c ^ {24'h0, d};
        repeat (8) r = (r >> 1) ^ (r[0] ? CRC_POLY : 32'h0);
        return r;
    endfunction

    task automatic note_error(input t_status code);
        if (fr_err == ST_OK) fr_err = code;
    endtask

    task automatic take_header_byte(input int pos, input logic [7:0] b);
        logic [31:0] v;
        v = {24'h0, b} << ((pos % 4) * 8);
        if (pos < OFS_VERSION) begin
            if (b != MAGIC[pos]) note_error(ST_MAGIC);
        end else if (pos == OFS_VERSION) begin
            if (b != FRAME_VER) note_error(ST_FORMAT);
        end else if (pos == OFS_LEVEL) begin
            if (b != lvl_cfg) note_error(ST_FORMAT);
        end else if (pos == OFS_FLAGS) begin
            if (b != FRAME_FLAGS) note_error(ST_FORMAT);
        end else if (pos == OFS_HSIZE) begin
            if (b != 8'(HDR_LEN)) note_error(ST_FORMAT);
        end else if (pos < OFS_WORDS + 16) begin
            case ((pos - OFS_WORDS) / 4)
                0:       fr_decl     |= v;
                1:       fr_comp     |= v;
                2:       fr_out_crc  |= v;
                default: fr_body_crc |= v;
            endcase
        end
    endtask

    task automatic check_header_words();
        logic [63:0] bound;
        bound = {32'h0, fr_decl} + {32'h0, fr_decl / 255} + 64'd16;
        if (fr_decl != fr_want) note_error(ST_MISMATCH);
        if (fr_decl > lim_cfg) note_error(ST_LARGE);
        if (fr_comp == 0 || {32'h0, fr_comp} > bound) note_error(ST_LENGTH);
    endtask

    // advance the frame state by one accepted byte and queue what should come out
    task automatic track_frame_byte(input logic [7:0] b, input logic last,
                                    input logic [31:0] want);
        t_frame_out r;
        logic       passed;
        passed = 1'b0;
        if (fr_hdr == 0) begin
            fr_err = ST_OK;
            fr_decl = '0;
            fr_comp = '0;
            fr_body_cnt = '0;
            fr_crc = ALL_ONES;
            fr_body_crc = '0;
            fr_out_crc = '0;
            fr_want = want;
        end
        if (fr_hdr < HDR_LEN) begin
            take_header_byte(fr_hdr, b);
            fr_hdr++;
            if (fr_hdr == HDR_LEN) check_header_words();
        end else begin
            if (fr_body_cnt >= fr_comp) note_error(ST_LENGTH);
            if (fr_body_cnt != ALL_ONES) fr_body_cnt++;
            fr_crc = crc_step(fr_crc, b);
            passed = (fr_err == ST_OK);
        end
        r.status = fr_err;
        if (last) begin
            if (fr_hdr < HDR_LEN) begin
                r.status = ST_TRUNC;
            end else begin
                if (fr_body_cnt != fr_comp) note_error(ST_LENGTH);
                if (~fr_crc != fr_body_crc) note_error(ST_CRC);
                r.status = fr_err;
            end
            ends_by_status[r.status]++;
            n_frames++;
        end
        if (passed || last) begin
            r.body  = passed ? b : 8'h00;
            r.valid = passed;
            r.last  = last;
            r.decl  = last ? fr_decl : 32'h0;
            r.ocrc  = last ? fr_out_crc : 32'h0;
            frame_out_q.push_back(r);
        end
        if (last) fr_hdr = 0;
    endtask

    task automatic push_byte(input logic [7:0] d, input logic last, input logic [31:0] want);
        t_payload_byte p;
        p.data = d;
        p.last = last;
        p.want = want;
        payload_q.push_back(p);
        bytes_queued++;
    endtask

    // build one frame; keep > 0 cuts it after that many bytes
    task automatic queue_frame(input logic [31:0] want, input logic [31:0] decl,
                               input logic [31:0] comp, input int body_len,
                               input int bad_pos, input bit bad_crc, input int keep);
        logic [7:0]  fb[$];
        logic [31:0] words[4];
        logic [31:0] crc_acc;
        logic [7:0]  body[$];
        int          n;
        for (int i = 0; i < body_len; i++) body.push_back(8'($urandom_range(255)));
        crc_acc = ALL_ONES;
        foreach (body[i]) crc_acc = crc_step(crc_acc, body[i]);
        crc_acc = ~crc_acc;
        if (bad_crc) crc_acc ^= 32'h1 << $urandom_range(31);
        words = '{decl, comp, $urandom, crc_acc};
        for (int i = 0; i < 4; i++) fb.push_back(MAGIC[i]);
        fb.push_back(FRAME_VER);
        fb.push_back(lvl_cfg);
        fb.push_back(FRAME_FLAGS);
        fb.push_back(8'(HDR_LEN));
        foreach (words[w])
            for (int k = 0; k < 4; k++) fb.push_back(words[w][8*k +: 8]);
        if (bad_pos != NO_FLAW) fb[bad_pos] ^= 8'($urandom_range(255, 1));
        foreach (body[i]) fb.push_back(body[i]);
        n = (keep != FULL_FRAME && keep < fb.size()) ? keep : fb.size();
        for (int i = 0; i < n; i++)
            push_byte(fb[i], i == n - 1, (i == 0) ? want : $urandom);
    endtask

    task automatic rand_frame();
        int          pick;
        int          blen;
        int          maxlen;
        int          n;
        logic [31:0] decl;
        logic [31:0] want;
        logic [31:0] comp;
        logic [63:0] bound;
        pick = $urandom_range(99);
        decl = $urandom_range(lim_cfg, 0);
        bound = {32'h0, decl} + {32'h0, decl / 255} + 64'd16;
        maxlen = (bound < MAX_BODY) ? int'(bound) : MAX_BODY;
        blen = $urandom_range(maxlen, 1);
        comp = blen;
        want = decl;
        if (pick < 60) begin
            queue_frame(want, decl, comp, blen, NO_FLAW, 1'b0, FULL_FRAME);
        end else if (pick < 66) begin
            queue_frame(want, decl, comp, blen, $urandom_range(OFS_HSIZE), 1'b0, FULL_FRAME);
        end else if (pick < 71) begin
            queue_frame(want, decl, comp, blen, NO_FLAW, 1'b1, FULL_FRAME);
        end else if (pick < 75) begin
            want = decl ^ $urandom_range(32'hFFFFFFFF, 1);
            queue_frame(want, decl, comp, blen, NO_FLAW, 1'b0, FULL_FRAME);
        end else if (pick < 79) begin
            if (lim_cfg != ALL_ONES) decl = $urandom_range(ALL_ONES, lim_cfg + 1);
            queue_frame(decl, decl, comp, blen, NO_FLAW, 1'b0, FULL_FRAME);
        end else if (pick < 83) begin
            if ($urandom_range(1) == 0) begin
                queue_frame(want, decl, 32'h0, blen, NO_FLAW, 1'b0, FULL_FRAME);
            end else begin
                decl = $urandom_range(24);
                comp = decl + decl / 255 + 16 + $urandom_range(8, 1);
                queue_frame(decl, decl, comp, comp, NO_FLAW, 1'b0, FULL_FRAME);
            end
        end else if (pick < 88) begin
            if ($urandom_range(1) == 0) blen = comp + $urandom_range(5, 1);
            else blen = $urandom_range(comp - 1, 0);
            queue_frame(want, decl, comp, blen, NO_FLAW, 1'b0, FULL_FRAME);
        end else if (pick < 94) begin
            queue_frame(want, decl, comp, blen, NO_FLAW, 1'b0, $urandom_range(HDR_LEN - 1, 1));
        end else begin
            n = $urandom_range(MAX_BODY, 1);
            for (int i = 0; i < n; i++)
                push_byte(8'($urandom_range(255)), i == n - 1, $urandom);
        end
    endtask

    task automatic fill_random(input int n_bytes);
        int goal;
        goal = bytes_queued + n_bytes;
        while (bytes_queued < goal) rand_frame();
    endtask

    task automatic wait_drained();
        while (payload_q.size() != 0 || s_axis_tvalid || frame_out_q.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_LEVEL) lvl_cfg = data[7:0];
        else lim_cfg = data;
    endtask

    // let header bytes still in flight settle before touching the registers
    task automatic reconfigure(input logic [7:0] lvl, input logic [31:0] lim);
        wait_drained();
        repeat (QUIET_CYCLES) @(posedge i_clk);
        apb_write(ADDR_LEVEL, {24'h0, lvl});
        apb_write(ADDR_LIMIT, lim);
    endtask

    task automatic queue_directed();
        logic [31:0] big;
        big = LIMIT_RESET + 1;
        queue_frame(32'd100, 32'd100, 32'd1, 1, NO_FLAW, 1'b0, FULL_FRAME);
        queue_frame(LIMIT_RESET, LIMIT_RESET, 32'd40, 40, NO_FLAW, 1'b0, FULL_FRAME);
        queue_frame(32'd0, 32'd0, 32'd16, 16, NO_FLAW, 1'b0, FULL_FRAME);
        queue_frame(32'd50, 32'd50, 32'd2, 2, 0, 1'b0, FULL_FRAME);
        queue_frame(32'd50, 32'd50, 32'd2, 2, 3, 1'b0, FULL_FRAME);
        for (int p = OFS_VERSION; p <= OFS_HSIZE; p++)
            queue_frame(32'd50, 32'd50, 32'd2, 2, p, 1'b0, FULL_FRAME);
        queue_frame(32'd51, 32'd50, 32'd2, 2, NO_FLAW, 1'b0, FULL_FRAME);
        queue_frame(big, big, 32'd5, 5, NO_FLAW, 1'b0, FULL_FRAME);
        queue_frame(ALL_ONES, ALL_ONES, 32'd3, 3, NO_FLAW, 1'b0, FULL_FRAME);
        queue_frame(32'd50, 32'd50, 32'd0, 3, NO_FLAW, 1'b0, FULL_FRAME);
        queue_frame(32'd0, 32'd0, 32'd17, 17, NO_FLAW, 1'b0, FULL_FRAME);
        queue_frame(32'd50, 32'd50, 32'd3, 6, NO_FLAW, 1'b0, FULL_FRAME);
        queue_frame(32'd50, 32'd50, 32'd6, 2, NO_FLAW, 1'b0, FULL_FRAME);
        // header complete, no body at all
        queue_frame(32'd50, 32'd50, 32'd4, 0, NO_FLAW, 1'b0, FULL_FRAME);
        queue_frame(32'd50, 32'd50, 32'd8, 8, NO_FLAW, 1'b1, FULL_FRAME);
        queue_frame(32'd50, 32'd50, 32'd8, 8, NO_FLAW, 1'b0, 1);
        queue_frame(32'd50, 32'd50, 32'd8, 8, NO_FLAW, 1'b0, HDR_LEN - 1);
        // truncation wins over a bad magic
        queue_frame(32'd50, 32'd50, 32'd8, 8, 1, 1'b0, 2);
    endtask

    // sender: hold the offered byte until it is taken, predict at the transfer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                track_frame_byte(cur_byte.data, cur_byte.last, cur_byte.want);
                n_in++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (payload_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                    cur_byte = payload_q.pop_front();
                    s_axis_tdata  <= {cur_byte.want, cur_byte.data};
                    s_axis_tlast  <= cur_byte.last;
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver ready, with one long hold-off when armed
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_arm && !hold_done) begin
            m_axis_tready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    task automatic check_field(input string what, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (got_v !== want_v) begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, want_v, got_v);
            n_fail++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            n_results++;
            if (frame_out_q.size() == 0) begin
                $display("%0t: result transfer with nothing expected: expected none, actual %0h",
                         $time, m_axis_tdata);
                n_fail++;
            end else begin
                exp_out = frame_out_q.pop_front();
                check_field("body_byte", {24'h0, exp_out.body}, {24'h0, m_axis_tdata[7:0]});
                check_field("byte_valid", {31'h0, exp_out.valid}, {31'h0, m_axis_tuser});
                check_field("frame_end", {31'h0, exp_out.last}, {31'h0, m_axis_tlast});
                check_field("status", {29'h0, exp_out.status}, {29'h0, m_axis_tdata[10:8]});
                check_field("stated_size", exp_out.decl, m_axis_tdata[42:11]);
                check_field("output_crc", exp_out.ocrc, m_axis_tdata[74:43]);
                check_field("padding", 32'h0, {27'h0, m_axis_tdata[79:75]});
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                     $time, stall_cycles, frame_out_q.size());
            $display("Some tests failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        src_idle_pct = 0;
        sink_stall_pct = 0;
        queue_directed();
        fill_random(PHASE_BYTES);

        reconfigure(8'h00, 32'h0);
        src_idle_pct = 56;
        sink_stall_pct = 0;
        fill_random(PHASE_BYTES);

        reconfigure(8'hFF, ALL_ONES);
        src_idle_pct = 0;
        sink_stall_pct = 56;
        fill_random(PHASE_BYTES);

        reconfigure(8'($urandom_range(255)), $urandom);
        src_idle_pct = 16;
        sink_stall_pct = 16;
        fill_random(PHASE_BYTES);

        // back-pressure: long bodies while the receiver holds off
        reconfigure(LEVEL_RESET, LIMIT_RESET);
        src_idle_pct = 0;
        sink_stall_pct = 0;
        repeat (3) queue_frame(32'd1000, 32'd1000, 32'd60, 60, NO_FLAW, 1'b0, FULL_FRAME);
        hold_arm = 1'b1;
        fill_random(PHASE_BYTES);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Covered %0d bytes in %0d frames, %0d result transfers, five register settings",
                 n_in, n_frames, n_results);
        $display("Frame ends by status ok/trunc/magic/format/mismatch/large/length/crc:");
        $display("    %0d %0d %0d %0d %0d %0d %0d %0d",
                 ends_by_status[0], ends_by_status[1], ends_by_status[2], ends_by_status[3],
                 ends_by_status[4], ends_by_status[5], ends_by_status[6], ends_by_status[7]);
        if (n_fail == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
